/* design/mcsw_pkg.sv */
// shared types and constants of the multi-channel silence watchdog
package mcsw_pkg;

  localparam logic [63:0] THRESHOLD_RESET = 64'd3000000000;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_EPOCH  = 1'b1;

  localparam logic EVT_SILENT  = 1'b0;
  localparam logic EVT_RESUMED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  // one channel's tracking state
  typedef struct packed {
    logic        silent;
    logic [63:0] last_seen;
  } cell_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel;
    logic [63:0] time_ns;
    logic [63:0] gap;
    logic [31:0] epoch;
  } evt_t;

  typedef struct packed {
    logic evt_ready;
    logic pend_valid;
  } buf_stat_t;

endpackage

/* design/mcsw_cell.sv */
// one channel cell of the rotating state ring
module mcsw_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clear_i,
  input  logic           shift_i,
  input  mcsw_pkg::cell_t shift_in_i,
  input  logic           wr_i,
  input  logic [63:0]    wr_time_i,
  output mcsw_pkg::cell_t state_o
);
  import mcsw_pkg::*;

  cell_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (clear_i) begin
      state_d = '0;
    end else if (shift_i) begin
      state_d = shift_in_i;
    end else if (wr_i) begin
      state_d.silent    = 1'b0;
      state_d.last_seen = wr_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

/* design/mcsw_evt_buf.sv */
// one-event holding stage plus output register, tags the last event of a run
module mcsw_evt_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mcsw_pkg::evt_t     evt_i,
  input  logic               flush_i,
  output mcsw_pkg::buf_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcsw_pkg::evt_t     out_evt_o,
  output logic               out_last_o
);
  import mcsw_pkg::*;

  logic pend_q, pend_d;
  evt_t pend_evt_q;
  logic out_valid_q, out_valid_d;
  evt_t out_evt_q;
  logic out_last_q;
  logic out_free;
  logic move;

  assign out_free = !out_valid_q || out_ready_i;
  // held event leaves once a successor shows up or the run ends
  assign move     = pend_q && out_free && (push_i || flush_i);

  always_comb begin
    pend_d = pend_q;
    if (push_i) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pend_evt_q <= evt_i;
    end
    if (move) begin
      out_evt_q  <= pend_evt_q;
      out_last_q <= !push_i;
    end
  end

  assign stat_o.evt_ready  = !pend_q || out_free;
  assign stat_o.pend_valid = pend_q;
  assign out_valid_o       = out_valid_q;
  assign out_evt_o         = out_evt_q;
  assign out_last_o        = out_last_q;

endmodule

/* design/multi_channel_silence_watchdog.sv */
// A sample is taken in idle, then passes the update state, a sweep over all CHANNELS cells
// and the flush state. A sample that emits events stays in flush until its held event has
// moved on, and output stalls can hold the update, the sweep and the flush. The sweep rotates
// the ring of channel cells by one cell a cycle past the head checker while no silent event
// waits for room. An epoch item is taken in idle and produces no transfer on the output.
// Reset clears all channels and loads the default silence threshold; no clearing pass.
module multi_channel_silence_watchdog #(
  parameter int CHANNELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [3:0]  channel_i,
  input  logic        tracked_i,
  input  logic [63:0] sample_time_i,
  input  logic [31:0] run_epoch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_kind_o,
  output logic [3:0]  event_channel_o,
  output logic [63:0] event_time_o,
  output logic [63:0] gap_ns_o,
  output logic [31:0] event_epoch_o,
  output logic        last_of_run_o
);
  import mcsw_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  state_e          state_q, state_d;
  logic [63:0]     thr_q;
  logic [3:0]      ch_q;
  logic            trk_q;
  logic [63:0]     now_q;
  logic [31:0]     ep_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W+3:0] idx_ext;

  cell_t           cells [CHANNELS];
  cell_t           head_upd;
  cell_t           sel_cell;
  logic [CHANNELS-1:0] sel;
  logic            in_range;
  logic [64:0]     diff;
  logic            hit;
  logic            need_resume;
  logic            accept;

  logic            clear;
  logic            upd_go;
  logic            shift;
  logic            push;
  logic            flush;
  logic            step_done;
  evt_t            evt;
  evt_t            out_evt;
  buf_stat_t       buf_stat;

  assign accept = in_valid_i && in_ready_o;

  // cell at fixed position j holds channel j whenever the ring is at rest
  always_comb begin
    sel_cell = '0;
    for (int j = 0; j < CHANNELS; j++) begin
      sel[j] = ({3'b000, ch_q} == 7'(j));
      if (sel[j]) begin
        sel_cell = sel_cell | cells[j];
      end
    end
  end
  assign in_range    = |sel;
  assign need_resume = trk_q && in_range && sel_cell.silent;

  // head check: not yet silent, seen before, later than last seen and quiet long enough
  assign diff = {1'b0, now_q} - {1'b0, cells[0].last_seen};
  assign hit  = !cells[0].silent && (cells[0].last_seen != 64'd0) && !diff[64]
                && (diff[63:0] != 64'd0) && (diff[63:0] >= thr_q);

  assign head_upd.silent    = cells[0].silent | hit;
  assign head_upd.last_seen = cells[0].last_seen;

  assign idx_ext = {4'b0000, idx_q};

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_cell
      cell_t nb;
      if (g == CHANNELS - 1) begin : g_tail
        assign nb = head_upd;
      end else begin : g_mid
        assign nb = cells[g+1];
      end
      mcsw_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .clear_i    (clear),
        .shift_i    (shift),
        .shift_in_i (nb),
        .wr_i       (upd_go && sel[g]),
        .wr_time_i  (now_q),
        .state_o    (cells[g])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_SAMPLE)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (step_done) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (shift && (idx_q == IDX_LAST)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!buf_stat.pend_valid) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready_o = 1'b0;
    clear      = 1'b0;
    upd_go     = 1'b0;
    shift      = 1'b0;
    push       = 1'b0;
    flush      = 1'b0;
    step_done  = 1'b0;
    evt.kind    = EVT_SILENT;
    evt.channel = idx_ext[3:0];
    evt.time_ns = now_q;
    evt.gap     = diff[63:0];
    evt.epoch   = ep_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        clear      = in_valid_i && (req_type_i == REQ_EPOCH);
      end
      ST_UPDATE: begin
        evt.kind    = EVT_RESUMED;
        evt.channel = ch_q;
        evt.gap     = now_q - sel_cell.last_seen;
        if (need_resume) begin
          push      = buf_stat.evt_ready;
          upd_go    = buf_stat.evt_ready;
          step_done = buf_stat.evt_ready;
        end else begin
          upd_go    = trk_q && in_range;
          step_done = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (hit) begin
          push  = buf_stat.evt_ready;
          shift = buf_stat.evt_ready;
        end else begin
          shift = 1'b1;
        end
      end
      ST_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (state_q == ST_UPDATE) begin
      idx_d = '0;
    end else if (shift) begin
      idx_d = IDX_W'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= THRESHOLD_RESET;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // sample fields held for the whole run
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= channel_i;
      trk_q <= tracked_i;
      now_q <= sample_time_i;
      ep_q  <= run_epoch_i;
    end
  end

  mcsw_evt_buf u_evt_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .evt_i       (evt),
    .flush_i     (flush),
    .stat_o      (buf_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_evt_o   (out_evt),
    .out_last_o  (last_of_run_o)
  );

  assign event_kind_o    = out_evt.kind;
  assign event_channel_o = out_evt.channel;
  assign event_time_o    = out_evt.time_ns;
  assign gap_ns_o        = out_evt.gap;
  assign event_epoch_o   = out_evt.epoch;

endmodule

/* test/tb_multi_channel_silence_watchdog.sv */
// self-checking testbench for the multi-channel silence watchdog
`timescale 1ns / 100ps

module tb_multi_channel_silence_watchdog;
  import mcsw_pkg::*;

  localparam int CHANNEL_COUNT   = 16;
  localparam int ITEMS_PER_PHASE = 41;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = CHANNEL_COUNT + 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TIMEOUT_NS      = 4_000_000;
  localparam logic [63:0] STEP_CAP = 64'h0000_0100_0000_0000;
  localparam logic [63:0] PHASE_THRESHOLDS [NUM_PHASES] = '{
    64'd1, 64'd1000, 64'hFFFF_FFFF_FFFF_FFFF, 64'd250_000, STEP_CAP, THRESHOLD_RESET
  };

  typedef struct packed {
    logic        req_type;
    logic [3:0]  channel;
    logic        tracked;
    logic [63:0] sample_time;
    logic [31:0] run_epoch;
  } sample_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel;
    logic [63:0] stamp;
    logic [63:0] gap;
    logic [31:0] epoch;
    logic        closes_run;
  } watchdog_event_t;

  // per-channel heartbeat tracker and the queue of events still owed by the block
  class silence_tracker;
    logic [63:0]     threshold;
    logic [63:0]     last_seen [CHANNEL_COUNT];
    logic            silent [CHANNEL_COUNT];
    watchdog_event_t pending_events [$];
    int unsigned     errors;
    int unsigned     silent_checked;
    int unsigned     resumed_checked;

    function new();
      threshold = THRESHOLD_RESET;
      forget_all();
    endfunction

    function void forget_all();
      foreach (last_seen[i]) begin
        last_seen[i] = '0;
        silent[i]    = 1'b0;
      end
    endfunction

    function void note_item(sample_item_t item);
      watchdog_event_t run [$];
      watchdog_event_t ev;
      logic [63:0]     now;
      if (item.req_type == REQ_EPOCH) begin
        forget_all();
        return;
      end
      now = item.sample_time;
      // a 4-bit channel always falls inside the 16 tracked channels
      if (item.tracked) begin
        if (silent[item.channel]) begin
          ev = '{EVT_RESUMED, item.channel, now, now - last_seen[item.channel],
                 item.run_epoch, 1'b0};
          run.push_back(ev);
          silent[item.channel] = 1'b0;
        end
        last_seen[item.channel] = now;
      end
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        if (!silent[i] && last_seen[i] != '0 && now > last_seen[i] &&
            now - last_seen[i] >= threshold) begin
          ev = '{EVT_SILENT, 4'(i), now, now - last_seen[i], item.run_epoch, 1'b0};
          run.push_back(ev);
          silent[i] = 1'b1;
        end
      end
      if (run.size() > 0) run[run.size() - 1].closes_run = 1'b1;
      foreach (run[i]) pending_events.push_back(run[i]);
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_event(watchdog_event_t got);
      watchdog_event_t want;
      bit              ok;
      if (pending_events.size() == 0) begin
        $display("%0t ns: unexpected event, expected none, actual kind %0d channel %0d gap %0h",
                 $time, got.kind, got.channel, got.gap);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      ok  = field_ok("event_kind", 64'(want.kind), 64'(got.kind));
      ok &= field_ok("event_channel", 64'(want.channel), 64'(got.channel));
      ok &= field_ok("event_time", want.stamp, got.stamp);
      ok &= field_ok("gap_ns", want.gap, got.gap);
      ok &= field_ok("event_epoch", 64'(want.epoch), 64'(got.epoch));
      ok &= field_ok("last_of_run", 64'(want.closes_run), 64'(got.closes_run));
      if (!ok) errors++;
      else if (want.kind == EVT_SILENT) silent_checked++;
      else resumed_checked++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [3:0]  channel_i;
  logic        tracked_i;
  logic [63:0] sample_time_i;
  logic [31:0] run_epoch_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        event_kind_o;
  logic [3:0]  event_channel_o;
  logic [63:0] event_time_o;
  logic [63:0] gap_ns_o;
  logic [31:0] event_epoch_o;
  logic        last_of_run_o;

  silence_tracker tracker = new();
  bit             hold_off_req;
  bit             steady_flow;
  int unsigned    items_sent;
  int unsigned    epochs_sent;
  int unsigned    settings_written;

  multi_channel_silence_watchdog #(
    .CHANNELS(CHANNEL_COUNT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .channel_i      (channel_i),
    .tracked_i      (tracked_i),
    .sample_time_i  (sample_time_i),
    .run_epoch_i    (run_epoch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .event_channel_o(event_channel_o),
    .event_time_o   (event_time_o),
    .gap_ns_o       (gap_ns_o),
    .event_epoch_o  (event_epoch_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d events still owed", tracker.pending_events.size());
    $display("** multi_channel_silence_watchdog: FAILED **");
    $finish;
  end

  // event transfers, sampled with the values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_event('{event_kind_o, event_channel_o, event_time_o, gap_ns_o,
                            event_epoch_o, last_of_run_o});
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (steady_flow ? 1 : $urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic offer_sample(input logic req, input logic [3:0] ch, input logic trk,
                              input logic [63:0] stamp, input logic [31:0] epoch);
    sample_item_t item;
    item = '{req, ch, trk, stamp, epoch};
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= item.req_type;
    channel_i       <= item.channel;
    tracked_i       <= item.tracked;
    sample_time_i   <= item.sample_time;
    run_epoch_i     <= item.run_epoch;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_item(item);
    items_sent++;
    if (req == REQ_EPOCH) epochs_sent++;
  endtask

  // a sample that causes no event may still be in the sweep, so wait a bit more
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (tracker.pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [63:0] value);
    drain_outputs();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.threshold = value;
    settings_written++;
  endtask

  initial begin
    int          pick;
    logic [63:0] stamp;
    logic [63:0] scale;
    logic [63:0] stream_time;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    req_type_i      <= REQ_SAMPLE;
    channel_i       <= '0;
    tracked_i       <= 1'b0;
    sample_time_i   <= '0;
    run_epoch_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset threshold
    offer_sample(REQ_SAMPLE, 4'd0, 1'b1, 64'd1000, 32'd0);
    offer_sample(REQ_SAMPLE, 4'd15, 1'b1, 64'd0, 32'hFFFF_FFFF);  // zero time: never seen
    // untracked, quiet exactly for the threshold
    offer_sample(REQ_SAMPLE, 4'd1, 1'b0, THRESHOLD_RESET + 64'd1000, 32'd1);
    offer_sample(REQ_SAMPLE, 4'd0, 1'b1, THRESHOLD_RESET + 64'd1005, 32'd2);
    offer_sample(REQ_SAMPLE, 4'd2, 1'b1, THRESHOLD_RESET + 64'd500, 32'd3);  // time goes back
    offer_sample(REQ_SAMPLE, 4'd2, 1'b1, THRESHOLD_RESET + 64'd500, 32'd4);  // time stands still
    offer_sample(REQ_SAMPLE, 4'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    offer_sample(REQ_SAMPLE, 4'd0, 1'b1, 64'd5, 32'd5);  // resumed gap wraps
    offer_sample(REQ_EPOCH, 4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    offer_sample(REQ_SAMPLE, 4'd3, 1'b1, 64'd10, 32'd6);
    offer_sample(REQ_SAMPLE, 4'd4, 1'b1, THRESHOLD_RESET + 64'd9, 32'd7);   // one short
    offer_sample(REQ_SAMPLE, 4'd4, 1'b1, THRESHOLD_RESET + 64'd10, 32'd7);
    write_threshold(64'd0);  // anything seen earlier goes silent
    offer_sample(REQ_SAMPLE, 4'd5, 1'b1, THRESHOLD_RESET + 64'd20, 32'd8);
    offer_sample(REQ_SAMPLE, 4'd6, 1'b0, THRESHOLD_RESET + 64'd21, 32'd9);
    offer_sample(REQ_SAMPLE, 4'd10, 1'b1, 64'h8000_0000_0000_0000, 32'h8000_0000);

    // random part: mostly a rising time stream, with noise, steps back and epochs
    stream_time = 64'd100;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_threshold(PHASE_THRESHOLDS[p]);
      scale = (PHASE_THRESHOLDS[p] > STEP_CAP) ? STEP_CAP : PHASE_THRESHOLDS[p];
      if (p == NUM_PHASES - 1) steady_flow = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 0 && k == 12) hold_off_req = 1'b1;
        if (p == 1 && k == 20) drain_outputs();
        pick  = $urandom_range(0, 19);
        stamp = stream_time;
        case (pick)
          0: stamp = '0;
          1: stamp = {$urandom, $urandom};
          2: stamp = stream_time - 64'($urandom_range(0, 1000));
          3: stamp = stream_time;
          default: begin
            stream_time = stream_time + ({$urandom, $urandom} % (64'd3 * scale)) + 64'd1;
            stamp = stream_time;
          end
        endcase
        offer_sample(($urandom_range(0, 29) == 0) ? REQ_EPOCH : REQ_SAMPLE,
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 6) != 0),
                     stamp, $urandom);
      end
    end

    drain_outputs();
    $display("sent %0d items (%0d epoch boundaries) under %0d threshold settings",
             items_sent, epochs_sent, settings_written);
    $display("checked %0d silent and %0d resumed events, %0d errors",
             tracker.silent_checked, tracker.resumed_checked, tracker.errors);
    if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
      $display("** multi_channel_silence_watchdog: PASSED **");
    end else begin
      $display("** multi_channel_silence_watchdog: FAILED **");
    end
    $finish;
  end

endmodule

/* multi_channel_silence_watchdog.f */
design/mcsw_pkg.sv
design/mcsw_cell.sv
design/mcsw_evt_buf.sv
design/multi_channel_silence_watchdog.sv
test/tb_multi_channel_silence_watchdog.sv
